@@ hw/rtl/md5_digest_engine_macros.svh @@
// Assertion macros for the MD5 digest engine
`ifndef MD5_DIGEST_ENGINE_MACROS_SVH
`define MD5_DIGEST_ENGINE_MACROS_SVH

// Assert that a condition implies another on the same edge
`define MD5_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5 assertion failed");

// Assert that a condition implies another on the next edge
`define MD5_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5 assertion failed");

`endif

@@ hw/rtl/md5_pkg.sv @@
// Package with MD5 constants, tables and shared types
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned PAD_LIMIT = 56;

    typedef logic [31:0] word_t;

    // Round unit request and reply
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } md5_rnd_req_t;

    typedef struct packed {
        logic  done;
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } md5_rnd_rsp_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756;
            6'd2:  k = 32'h242070DB; 6'd3:  k = 32'hC1BDCEEE;
            6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501;
            6'd8:  k = 32'h698098D8; 6'd9:  k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/md5_round.sv @@
// Shared MD5 round unit: 64 rounds, one per cycle, over a 16-word block
module md5_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  md5_pkg::md5_rnd_req_t req,
    input  md5_pkg::word_t       msg_word,   // block word at msg_index
    output logic [3:0]           msg_index,
    output md5_pkg::md5_rnd_rsp_t rsp
);
    import md5_pkg::*;

    logic       busy_reg;
    logic [5:0] rnd_reg;
    word_t      a_reg, b_reg, c_reg, d_reg;
    logic       done_reg;

    word_t      f_val;
    word_t      sum;
    word_t      rot;
    logic [4:0] sh;

    // Select the boolean function and the message index for this round
    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                msg_index = rnd_reg[3:0];
            end
            2'd1:
            begin
                f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
                msg_index = 4'(5 * rnd_reg[3:0] + 1);
            end
            2'd2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                msg_index = 4'(3 * rnd_reg[3:0] + 5);
            end
            default:
            begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                msg_index = 4'(7 * rnd_reg[3:0]);
            end
        endcase
        sum = a_reg + f_val + round_k(rnd_reg) + msg_word;
        sh  = round_s(rnd_reg);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // Advance one round per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            c_reg <= req.c;
            d_reg <= req.d;
        end
        else if (busy_reg)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    assign rsp = '{done: done_reg, a: a_reg, b: b_reg, c: c_reg, d: d_reg};

endmodule

@@ hw/rtl/md5_digest_engine.sv @@
// MD5 digest engine: top level with block buffer, padding and output register
// Each beat is stored in the block buffer. The sixteenth word of a block, and the last
// beat, start the shared round unit. After that beat the block passes through a start
// state, 64 rounds at one per cycle, a state that sees the unit finish and a fold into
// the chain value. The last beat pads and compresses one or two final blocks. The
// digest is registered as the last fold completes and then appears on m_axis. The
// input is not ready while a block is in compression or a digest waits.
`include "md5_digest_engine_macros.svh"
module md5_digest_engine (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero pad
    input  logic         s_axis_tlast,  // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // digest_a, digest_b, digest_c, digest_d
);
    import md5_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COMP  = 6'b000010,
        ST_FOLD  = 6'b000100,
        ST_PAD2  = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_START = 6'b100000
    } state_t;

    state_t      state_reg;
    word_t       buf_mem [16];
    logic [3:0]  pos_reg;
    logic [63:0] bytes_reg;
    word_t       cv_reg [4];
    logic        final_reg;   // compressing a final block
    logic        second_reg;  // another padded block follows
    logic        spill_reg;   // pad byte opens the second padded block
    logic [127:0] out_reg;

    md5_rnd_req_t req;
    md5_rnd_rsp_t rsp;
    logic [3:0]   msg_index;
    word_t        msg_word;

    word_t       in_word;
    logic [2:0]  in_cnt;
    logic [1:0]  part;
    word_t       mask;
    word_t       tail_word;
    logic [63:0] bytes_next;
    logic [63:0] bit_len;
    logic        short_pad;
    word_t       len_lo;
    word_t       len_hi;

    assign in_word = s_axis_tdata[31:0];
    assign in_cnt  = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
    assign part    = in_cnt[1:0];
    assign mask    = (part == 2'd0) ? 32'h0 : ((32'h1 << {part, 3'b000}) - 32'h1);
    assign tail_word = in_cnt[2] ? in_word
                     : ((in_word & mask) | ({24'h0, PAD_BYTE} << {part, 3'b000}));
    assign bytes_next = bytes_reg + {61'h0, in_cnt};
    assign bit_len   = {bytes_reg[60:0], 3'b000};
    assign short_pad = ({pos_reg, 2'b00} + {3'b000, in_cnt}) < 7'(PAD_LIMIT);
    assign len_lo    = {bytes_next[28:0], 3'b000};
    assign len_hi    = bytes_next[60:29];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    // Message word read by the round unit
    assign msg_word = buf_mem[msg_index];

    assign req.start = (state_reg == ST_START);
    assign req.a = cv_reg[0];
    assign req.b = cv_reg[1];
    assign req.c = cv_reg[2];
    assign req.d = cv_reg[3];

    md5_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .msg_word  (msg_word),
        .msg_index (msg_index),
        .rsp       (rsp)
    );

    // Block buffer writes: data beats, padding and length words
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            if (!s_axis_tlast)
            begin
                buf_mem[pos_reg] <= in_word;
            end
            else
            begin
                // Fill the tail slot and everything above it; keep earlier words
                for (int i = 0; i < 16; i++)
                begin
                    if (4'(i) == pos_reg)
                    begin
                        buf_mem[i] <= tail_word;
                    end
                    else if (4'(i) > pos_reg)
                    begin
                        if (in_cnt[2] && (4'(i) == pos_reg + 4'd1))
                        begin
                            buf_mem[i] <= {24'h0, PAD_BYTE};
                        end
                        else if (short_pad && (i == 14))
                        begin
                            buf_mem[i] <= len_lo;
                        end
                        else if (short_pad && (i == 15))
                        begin
                            buf_mem[i] <= len_hi;
                        end
                        else
                        begin
                            buf_mem[i] <= '0;
                        end
                    end
                end
            end
        end
        else if (state_reg == ST_PAD2)
        begin
            // Second padded block: zeros, possibly the spilled pad byte, length
            buf_mem[0] <= spill_reg ? {24'h0, PAD_BYTE} : '0;
            for (int i = 1; i < 14; i++)
            begin
                buf_mem[i] <= '0;
            end
            buf_mem[14] <= bit_len[31:0];
            buf_mem[15] <= bit_len[63:32];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            bytes_reg  <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            spill_reg  <= 1'b0;
            cv_reg[0]  <= IV_A;
            cv_reg[1]  <= IV_B;
            cv_reg[2]  <= IV_C;
            cv_reg[3]  <= IV_D;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (!s_axis_tlast)
                        begin
                            pos_reg   <= pos_reg + 4'd1;
                            bytes_reg <= bytes_reg + 64'd4;
                            if (pos_reg == 4'd15)
                            begin
                                state_reg <= ST_START;
                            end
                        end
                        else
                        begin
                            bytes_reg  <= bytes_next;
                            final_reg  <= 1'b1;
                            second_reg <= !short_pad;
                            spill_reg  <= in_cnt[2] && (pos_reg == 4'd15);
                            state_reg  <= ST_START;
                        end
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_COMP;
                end
                ST_COMP:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    cv_reg[0] <= cv_reg[0] + rsp.a;
                    cv_reg[1] <= cv_reg[1] + rsp.b;
                    cv_reg[2] <= cv_reg[2] + rsp.c;
                    cv_reg[3] <= cv_reg[3] + rsp.d;
                    if (!final_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (second_reg)
                    begin
                        second_reg <= 1'b0;
                        state_reg  <= ST_PAD2;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_PAD2:
                begin
                    state_reg <= ST_START;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        cv_reg[0] <= IV_A;
                        cv_reg[1] <= IV_B;
                        cv_reg[2] <= IV_C;
                        cv_reg[3] <= IV_D;
                        pos_reg   <= '0;
                        bytes_reg <= '0;
                        final_reg <= 1'b0;
                        spill_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the digest as the last fold completes
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FOLD) && final_reg && !second_reg)
        begin
            out_reg <= {cv_reg[3] + rsp.d, cv_reg[2] + rsp.c,
                        cv_reg[1] + rsp.b, cv_reg[0] + rsp.a};
        end
    end

    `MD5_ASSERT_IMPL(a_out_final, m_axis_tvalid, final_reg && !second_reg)
    `MD5_ASSERT_NEXT(a_start_runs, req.start, state_reg == ST_COMP)
    `MD5_ASSERT_IMPL(a_done_in_comp, rsp.done, state_reg == ST_COMP)

endmodule
